FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL. Each use stands on a line of its
// own and names the clock and reset of the including module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SQE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SQE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/sqe_pkg.sv
// ---------------------------------------------------------------------------
// sqe_pkg
// Types and constants shared by the stack/queue engine and its cells.
// ---------------------------------------------------------------------------
package sqe_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_PALL = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_POP  = 3'd3,
    CMD_SWAP = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PEEK_EMPTY = 3'd1,
    ST_POP_EMPTY  = 3'd2,
    ST_SWAP_SHORT = 3'd3,
    ST_FULL       = 3'd4,
    ST_HALTED     = 3'd5
  } status_t;

  // Operation applied by every cell of the chain in the same cycle.
  typedef enum logic [2:0] {
    CH_HOLD,
    CH_PUSH_FRONT,
    CH_PUSH_BACK,
    CH_POP,
    CH_SWAP,
    CH_ROTATE
  } chain_op_t;

  typedef struct packed {
    chain_op_t           op;
    logic [DATA_W-1:0]   value;
  } chain_ctl_t;

  typedef struct packed {
    logic printing;
    logic halted;
  } sqe_sts_t;

endpackage

FILE: sv/sqe_cell.sv
// ---------------------------------------------------------------------------
// sqe_cell
// One entry of the list. The front entry lives in cell 0; most operations
// move words between neighbouring cells, push at the back writes the cell after the tail.
// ---------------------------------------------------------------------------
module sqe_cell import sqe_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                        clk,
  input  chain_ctl_t                  ctl,
  input  logic [$clog2(DEPTH+1)-1:0]  count,
  input  logic [DATA_W-1:0]           prev_val,
  input  logic [DATA_W-1:0]           next_val,
  input  logic [DATA_W-1:0]           head_val,
  output logic [DATA_W-1:0]           val
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] val_r, val_nxt;
  logic              is_tail, is_next;

  assign is_tail = (count == CW'(IDX + 1));
  assign is_next = (count == CW'(IDX));

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      // Cell 0 sees the pushed word as its previous neighbour.
      CH_PUSH_FRONT: val_nxt = prev_val;
      CH_PUSH_BACK: begin
        if (is_next) val_nxt = ctl.value;
      end
      CH_POP:        val_nxt = next_val;
      CH_SWAP: begin
        if (IDX == 0)      val_nxt = next_val;
        else if (IDX == 1) val_nxt = prev_val;
      end
      // The front word wraps round to the tail, so a full pass restores order.
      CH_ROTATE:     val_nxt = is_tail ? head_val : next_val;
      default:       val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

FILE: sv/sqe_ctrl.sv
// ---------------------------------------------------------------------------
// sqe_ctrl
// Command decoder, entry count, sticky error flag and result register.
// Drives one chain operation per cycle and streams print-all words.
// ---------------------------------------------------------------------------
module sqe_ctrl import sqe_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_stack_mode,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_command,
  input  logic signed [DATA_W-1:0]    in_push_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DATA_W-1:0]    out_entry_value,
  output logic                        out_has_value,
  output logic [2:0]                  out_status,
  output logic                        out_last,
  input  logic [DATA_W-1:0]           head_val,
  output chain_ctl_t                  ctl,
  output logic [$clog2(DEPTH+1)-1:0]  count,
  output sqe_sts_t                    sts
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_PRINT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     remain_r, remain_nxt;
  logic              halted_r, halted_nxt;
  logic              mode_r, mode_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_has_r, out_has_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free, accept;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    remain_nxt     = remain_r;
    halted_nxt     = halted_r;
    mode_nxt       = (cfg_valid && cfg_ready) ? cfg_stack_mode : mode_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_has_nxt    = out_has_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ctl.op         = CH_HOLD;
    ctl.value      = in_push_value;

    if (accept) begin
      // Unless overridden below, one word: no value, status ok, last.
      out_valid_nxt  = 1'b1;
      out_value_nxt  = '0;
      out_has_nxt    = 1'b0;
      out_status_nxt = ST_OK;
      out_last_nxt   = 1'b1;
      if (halted_r) begin
        out_status_nxt = ST_HALTED;
      end else begin
        case (in_command)
          CMD_PUSH: begin
            if (count_r == CW'(DEPTH)) begin
              out_status_nxt = ST_FULL;
              halted_nxt     = 1'b1;
            end else begin
              ctl.op    = mode_r ? CH_PUSH_FRONT : CH_PUSH_BACK;
              count_nxt = count_r + CW'(1);
            end
          end
          CMD_PALL: begin
            if (count_r != '0) begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_PRINT;
              remain_nxt    = count_r;
            end
          end
          CMD_PEEK: begin
            if (count_r == '0) begin
              out_status_nxt = ST_PEEK_EMPTY;
              halted_nxt     = 1'b1;
            end else begin
              out_value_nxt = head_val;
              out_has_nxt   = 1'b1;
            end
          end
          CMD_POP: begin
            if (count_r == '0) begin
              out_status_nxt = ST_POP_EMPTY;
              halted_nxt     = 1'b1;
            end else begin
              ctl.op    = CH_POP;
              count_nxt = count_r - CW'(1);
            end
          end
          CMD_SWAP: begin
            if (count_r < CW'(2)) begin
              out_status_nxt = ST_SWAP_SHORT;
              halted_nxt     = 1'b1;
            end else begin
              ctl.op = CH_SWAP;
            end
          end
          default: ;
        endcase
      end
    end else if (state_r == S_PRINT && out_free) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = head_val;
      out_has_nxt    = 1'b1;
      out_status_nxt = ST_OK;
      out_last_nxt   = (remain_r == CW'(1));
      ctl.op         = CH_ROTATE;
      remain_nxt     = remain_r - CW'(1);
      if (remain_r == CW'(1)) state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      halted_r    <= 1'b0;
      mode_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      halted_r    <= halted_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r  <= out_value_nxt;
    out_has_r    <= out_has_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_entry_value = out_value_r;
  assign out_has_value   = out_has_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;
  assign count           = count_r;
  assign sts.printing    = (state_r == S_PRINT);
  assign sts.halted      = halted_r;

endmodule

FILE: sv/stack_queue_engine.sv
// ---------------------------------------------------------------------------
// stack_queue_engine: bounded stack/queue of signed words in a row of cells.
// Push, pop, peek, swap and unknown commands: result word in the cycle after
// acceptance, next command accepted once out_ready takes it. Print all: for N > 0
// entries, N words from the front cell, one per cycle while out_ready is high.
// Synchronous active-low reset clears count, error flag and mode (stack).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stack_queue_engine import sqe_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_stack_mode,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_command,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_entry_value,
  output logic                     out_has_value,
  output logic [2:0]               out_status,
  output logic                     out_last
);

  localparam int CW = $clog2(DEPTH + 1);

  chain_ctl_t        ctl;
  logic [CW-1:0]     count;
  sqe_sts_t          sts;
  logic [DATA_W-1:0] cell_val [DEPTH];

  sqe_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_stack_mode  (cfg_stack_mode),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_value (out_entry_value),
    .out_has_value   (out_has_value),
    .out_status      (out_status),
    .out_last        (out_last),
    .head_val        (cell_val[0]),
    .ctl             (ctl),
    .count           (count),
    .sts             (sts)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] prev_w, next_w;

    // A word pushed at the front enters cell 0; the far end wraps to the front.
    if (g == 0) begin : g_first
      assign prev_w = ctl.value;
    end else begin : g_mid_prev
      assign prev_w = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign next_w = cell_val[0];
    end else begin : g_mid_next
      assign next_w = cell_val[g+1];
    end

    sqe_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count),
      .prev_val (prev_w),
      .next_val (next_w),
      .head_val (cell_val[0]),
      .val      (cell_val[g])
    );
  end

  `SQE_ASSERT(a_count_bound, count <= CW'(DEPTH), "entry count beyond depth")
  `SQE_ASSERT(a_halted_reply, (in_valid && in_ready && sts.halted) |=> (out_valid && out_status == ST_HALTED), "halted command not answered with halted status")
  `SQE_ASSERT(a_halted_frozen, sts.halted |=> $stable(count), "list changed while halted")
  `SQE_ASSERT_ALWAYS(a_print_blocks, sts.printing |-> !in_ready, "command accepted during print")

endmodule
